@@ sv/two_focus_parity_pattern_packer_macros.svh @@
// ----------------------------------------------------------------------------
// two_focus_parity_pattern_packer_macros
// assertion macros shared by the checker of the pattern packer
// ----------------------------------------------------------------------------
`ifndef TWO_FOCUS_PARITY_PATTERN_PACKER_MACROS_SVH
`define TWO_FOCUS_PARITY_PATTERN_PACKER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TFPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfpp assertion failed");

// next-cycle implication, disabled during reset
`define TFPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfpp assertion failed");

`endif

@@ sv/tfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// tfpp_pkg
// types and constants of the two focus parity pattern packer
// ----------------------------------------------------------------------------
package tfpp_pkg;

    localparam int PIX_W     = 12;
    localparam int WIDTH_W   = 13;
    localparam int FOCUS_W   = 12;
    localparam int BYTE_W    = 8;
    localparam int HELD_W    = 3;
    localparam int COORD_MAX = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    typedef logic [PIX_W-1:0]   pixel_coord_t;
    typedef logic [WIDTH_W-1:0] frame_width_t;
    typedef logic [FOCUS_W-1:0] focus_coord_t;
    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [HELD_W-1:0]  held_t;

    localparam frame_width_t FRAME_WIDTH_RST = 13'd640;
    localparam focus_coord_t FOCUS_RST       = 12'd0;
    localparam held_t        HELD_LAST       = 3'd7;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH = 3'd0,
        REG_FOCUS_A_X   = 3'd1,
        REG_FOCUS_A_Y   = 3'd2,
        REG_FOCUS_B_X   = 3'd3,
        REG_FOCUS_B_Y   = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_SUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ROOT,
        ST_PACK
    } state_t;

endpackage

@@ sv/tfpp_pixel_if.sv @@
// ----------------------------------------------------------------------------
// tfpp_pixel_if
// pixel coordinate channel, one request per pixel
// ----------------------------------------------------------------------------
interface tfpp_pixel_if;
    import tfpp_pkg::*;

    logic         valid;
    logic         ready;
    pixel_coord_t pixel_x;
    pixel_coord_t pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

@@ sv/tfpp_byte_if.sv @@
// ----------------------------------------------------------------------------
// tfpp_byte_if
// packed byte channel, one request per byte
// ----------------------------------------------------------------------------
interface tfpp_byte_if;
    import tfpp_pkg::*;

    logic  valid;
    logic  ready;
    byte_t packed_byte;
    logic  row_last;

    modport source (output valid, output packed_byte, output row_last, input ready);
    modport sink   (input valid, input packed_byte, input row_last, output ready);
endinterface

@@ sv/two_focus_parity_pattern_packer.sv @@
// ----------------------------------------------------------------------------
// two_focus_parity_pattern_packer
// parity of floor(sqrt(A*B)) per pixel, packed msb first into bytes
// ----------------------------------------------------------------------------
//  channel    dir  handshake          payload
//  pixel_in   in   valid / ready      pixel_x, pixel_y
//  byte_out   out  valid / ready      packed_byte, row_last
//  apb        in   psel/penable/pwrite frame_width, focus_a_x/y, focus_b_x/y
//
//  one pixel passes the bit-serial root loop, which retires one root bit
//  per cycle; around it sit accept, square, sum, two product halves and pack
//  reset takes effect at once, no clearing pass
//  the pack cycle waits while a byte is due and the output register is full and not taken
//  a pixel may be accepted while the previous byte still waits to be taken
// ----------------------------------------------------------------------------
module two_focus_parity_pattern_packer #(
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tfpp_pixel_if.sink                  pixel_in,
    tfpp_byte_if.source                 byte_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tfpp_pkg::APB_AW-1:0] paddr,
    input  logic [tfpp_pkg::APB_DW-1:0] pwdata,
    output logic [tfpp_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import tfpp_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int SQ_W   = 2 * C;
    localparam int SUM_W  = 2 * C + 1;
    localparam int LO_W   = C + 1;
    localparam int PROD_W = 2 * SUM_W;
    localparam int ROOT_W = SUM_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ROOT_W - 1);

    function automatic logic [C-1:0] abs_diff(input logic [C-1:0] p, input logic [C-1:0] q);
        logic [C-1:0] d;
        begin
            d = (p >= q) ? (p - q) : (q - p);
            return d;
        end
    endfunction

    // configuration
    frame_width_t frame_width_reg;
    focus_coord_t focus_a_x_reg;
    focus_coord_t focus_a_y_reg;
    focus_coord_t focus_b_x_reg;
    focus_coord_t focus_b_y_reg;

    // control
    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    byte_t              gather_reg, gather_next;
    held_t              held_reg, held_next;
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic [C-1:0]       dax_reg, dax_next;
    logic [C-1:0]       day_reg, day_next;
    logic [C-1:0]       dbx_reg, dbx_next;
    logic [C-1:0]       dby_reg, dby_next;
    logic               last_reg, last_next;
    logic [SQ_W-1:0]    sqax_reg, sqax_next;
    logic [SQ_W-1:0]    sqay_reg, sqay_next;
    logic [SQ_W-1:0]    sqbx_reg, sqbx_next;
    logic [SQ_W-1:0]    sqby_reg, sqby_next;
    logic [SUM_W-1:0]   a_reg, a_next;
    logic [SUM_W-1:0]   b_reg, b_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    byte_t              out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;

    logic [COORD_MAX-1:0] px_ext, py_ext, fax_ext, fay_ext, fbx_ext, fby_ext;
    logic [REM_W-1:0]     rem_shift;
    logic [REM_W-1:0]     trial;
    byte_t                gather_new;
    logic                 emit;
    logic                 cfg_write;
    reg_idx_t             cfg_idx;

    assign px_ext  = COORD_MAX'(pixel_in.pixel_x);
    assign py_ext  = COORD_MAX'(pixel_in.pixel_y);
    assign fax_ext = COORD_MAX'(focus_a_x_reg);
    assign fay_ext = COORD_MAX'(focus_a_y_reg);
    assign fbx_ext = COORD_MAX'(focus_b_x_reg);
    assign fby_ext = COORD_MAX'(focus_b_y_reg);

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_AW-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= FRAME_WIDTH_RST;
            focus_a_x_reg   <= FOCUS_RST;
            focus_a_y_reg   <= FOCUS_RST;
            focus_b_x_reg   <= FOCUS_RST;
            focus_b_y_reg   <= FOCUS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_FRAME_WIDTH: frame_width_reg <= pwdata[WIDTH_W-1:0];
                REG_FOCUS_A_X:   focus_a_x_reg   <= pwdata[FOCUS_W-1:0];
                REG_FOCUS_A_Y:   focus_a_y_reg   <= pwdata[FOCUS_W-1:0];
                REG_FOCUS_B_X:   focus_b_x_reg   <= pwdata[FOCUS_W-1:0];
                REG_FOCUS_B_Y:   focus_b_y_reg   <= pwdata[FOCUS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_FRAME_WIDTH: prdata = APB_DW'(frame_width_reg);
            REG_FOCUS_A_X:   prdata = APB_DW'(focus_a_x_reg);
            REG_FOCUS_A_Y:   prdata = APB_DW'(focus_a_y_reg);
            REG_FOCUS_B_X:   prdata = APB_DW'(focus_b_x_reg);
            REG_FOCUS_B_Y:   prdata = APB_DW'(focus_b_y_reg);
            default:         prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign pixel_in.ready       = (state_reg == ST_IDLE);
    assign byte_out.valid       = out_valid_reg;
    assign byte_out.packed_byte = out_byte_reg;
    assign byte_out.row_last    = out_last_reg;

    // one root digit: bring down two product bits, try 4*root+1
    assign rem_shift = {rem_reg[REM_W-3:0], prod_reg[PROD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};

    assign gather_new = gather_reg | (BYTE_W'(root_reg[0]) << (HELD_LAST - held_reg));
    assign emit       = (held_reg == HELD_LAST) || last_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        gather_next    = gather_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg && !byte_out.ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        dax_next       = dax_reg;
        day_next       = day_reg;
        dbx_next       = dbx_reg;
        dby_next       = dby_reg;
        last_next      = last_reg;
        sqax_next      = sqax_reg;
        sqay_next      = sqay_reg;
        sqbx_next      = sqbx_reg;
        sqby_next      = sqby_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        root_next      = root_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_in.valid)
                begin
                    dax_next   = abs_diff(px_ext[C-1:0], fax_ext[C-1:0]);
                    day_next   = abs_diff(py_ext[C-1:0], fay_ext[C-1:0]);
                    dbx_next   = abs_diff(px_ext[C-1:0], fbx_ext[C-1:0]);
                    dby_next   = abs_diff(py_ext[C-1:0], fby_ext[C-1:0]);
                    last_next  = ({1'b0, pixel_in.pixel_x} == (frame_width_reg - 13'd1));
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                sqax_next  = SQ_W'(dax_reg * dax_reg);
                sqay_next  = SQ_W'(day_reg * day_reg);
                sqbx_next  = SQ_W'(dbx_reg * dbx_reg);
                sqby_next  = SQ_W'(dby_reg * dby_reg);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                a_next     = SUM_W'(sqax_reg) + SUM_W'(sqay_reg);
                b_next     = SUM_W'(sqbx_reg) + SUM_W'(sqby_reg);
                state_next = ST_MUL_LO;
            end
            ST_MUL_LO:
            begin
                prod_next  = PROD_W'(a_reg * b_reg[LO_W-1:0]);
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                prod_next  = prod_reg + (PROD_W'(a_reg * b_reg[SUM_W-1:LO_W]) << LO_W);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = '0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                prod_next = prod_reg << 2;
                if (rem_shift >= trial)
                begin
                    rem_next  = rem_shift - trial;
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift;
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_PACK;
                end
            end
            ST_PACK:
            begin
                // hold while a byte is due and the previous one is not taken
                if (!(emit && out_valid_reg && !byte_out.ready))
                begin
                    if (emit)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = gather_new;
                        out_last_next  = last_reg;
                        gather_next    = '0;
                        held_next      = '0;
                    end
                    else
                    begin
                        gather_next = gather_new;
                        held_next   = held_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            gather_reg    <= '0;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            gather_reg    <= gather_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dax_reg      <= dax_next;
        day_reg      <= day_next;
        dbx_reg      <= dbx_next;
        dby_reg      <= dby_next;
        last_reg     <= last_next;
        sqax_reg     <= sqax_next;
        sqay_reg     <= sqay_next;
        sqbx_reg     <= sqbx_next;
        sqby_reg     <= sqby_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        prod_reg     <= prod_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

endmodule

@@ sv/tfpp_checker.sv @@
// ----------------------------------------------------------------------------
// tfpp_checker
// port-level checks of the pattern packer, bound to the top level
// ----------------------------------------------------------------------------
`include "two_focus_parity_pattern_packer_macros.svh"

module tfpp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [tfpp_pkg::BYTE_W-1:0] out_byte,
    input logic                  out_row_last,
    input logic                  pready
);
    import tfpp_pkg::*;

    // a pixel request keeps the block busy in the following cycle
    `TFPP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // a new byte is only loaded from the pack cycle, never while idle
    `TFPP_ASSERT_NOW(a_byte_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

    // a stalled byte holds
    `TFPP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(out_row_last))

    // the register port never waits
    `TFPP_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind two_focus_parity_pattern_packer tfpp_checker u_tfpp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (pixel_in.valid),
    .in_ready     (pixel_in.ready),
    .out_valid    (byte_out.valid),
    .out_ready    (byte_out.ready),
    .out_byte     (byte_out.packed_byte),
    .out_row_last (byte_out.row_last),
    .pready       (pready)
);
